### hdl/ffst_pkg.sv
`default_nettype none

package ffst_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned MODE_W   = 2;
   localparam int unsigned STATUS_W = 3;

   typedef logic [WORD_W-1:0]   word_type;
   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [STATUS_W-1:0] status_type;

   // operation codes carried by an input item
   localparam mode_type MODE_RECORD = 2'd0;
   localparam mode_type MODE_SEARCH = 2'd1;
   localparam mode_type MODE_UPDATE = 2'd2;
   localparam mode_type MODE_NOP    = 2'd3;

   // result status codes
   localparam status_type STATUS_OK       = 3'd0;
   localparam status_type STATUS_APPENDED = 3'd1;
   localparam status_type STATUS_NO_FIT   = 3'd2;
   localparam status_type STATUS_FULL     = 3'd3;
   localparam status_type STATUS_NO_HIT   = 3'd4;

   // one table entry: region offset and its free size
   typedef struct packed {
      word_type offset;
      word_type free;
   } entry_type;

endpackage : ffst_pkg

`default_nettype wire

### hdl/ffst_req_if.sv
`default_nettype none

interface ffst_req_if
   import ffst_pkg::*;
   ;
   logic     valid;
   logic     ready;
   mode_type mode;
   word_type region_offset;
   word_type amount;

   modport source (output valid, output mode, output region_offset, output amount,
                   input ready);
   modport sink   (input valid, input mode, input region_offset, input amount,
                   output ready);
endinterface : ffst_req_if

`default_nettype wire

### hdl/ffst_rsp_if.sv
`default_nettype none

interface ffst_rsp_if
   import ffst_pkg::*;
   ;
   logic       valid;
   logic       ready;
   status_type status;
   word_type   found_offset;
   word_type   found_free;

   modport source (output valid, output status, output found_offset, output found_free,
                   input ready);
   modport sink   (input valid, input status, input found_offset, input found_free,
                   output ready);
endinterface : ffst_rsp_if

`default_nettype wire

### hdl/first_fit_free_space_table.sv
// First-fit free-space table. Holds up to ENTRIES free regions (offset, free
// size) in an on-chip memory with one write and one registered read port.
// Each item on req_ch carries a mode: record overwrites the free size of the
// first entry with a matching offset or appends a new entry (status 3 when
// full), search returns the first entry whose free size is at least the
// requested amount and remembers it, update rewrites the remembered entry
// (offset forced to zero when the new size is zero). Exactly one result item
// leaves on rsp_ch per input item. Record and search walk the filled entries
// in order through a single shared compare unit, one memory read per cycle,
// between accept and result hand-off; update and the unused mode skip the
// scan. The block takes one item at a time; a new item is accepted while
// the previous result still waits on rsp_ch.
// No clearing pass is needed after reset: only filled entries are ever read.
`default_nettype none

module first_fit_free_space_table
   import ffst_pkg::*;
#(
   parameter int unsigned ENTRIES = 64
) (
   input wire logic  clock,
   input wire logic  reset,
   ffst_req_if.sink   req_ch,
   ffst_rsp_if.source rsp_ch
);

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CNT_W = IDX_W + 1;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]       state_ff, state_in;

   // latched item
   mode_type         mode_ff, mode_in;
   word_type         off_ff, off_in;
   word_type         amt_ff, amt_in;

   // table bookkeeping
   logic [CNT_W-1:0] used_ff, used_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             hit_valid_ff, hit_valid_in;

   // scan pointers: rd_ptr issues reads, chk_idx tags the data coming back
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic             chk_valid_ff, chk_valid_in;

   // pending result
   status_type       res_status_ff, res_status_in;
   word_type         res_off_ff, res_off_in;
   word_type         res_free_ff, res_free_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   word_type         rsp_off_ff, rsp_off_in;
   word_type         rsp_free_ff, rsp_free_in;

   // memory ports
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   entry_type        wr_entry;
   logic             rd_en;
   entry_type        rd_entry;

   logic             rd_more;
   logic             cmp_hit;
   logic             req_fire;

   ffst_table #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_entry (wr_entry),
      .rd_en    (rd_en),
      .rd_idx   (rd_ptr_ff[IDX_W-1:0]),
      .rd_entry (rd_entry)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // entries still to be read in this scan
   assign rd_more = (rd_ptr_ff < used_ff);

   // shared compare unit: offset match on record, fit test on search
   assign cmp_hit = (mode_ff == MODE_RECORD) ? (rd_entry.offset == off_ff)
                                             : (rd_entry.free >= amt_ff);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      off_in        = off_ff;
      amt_in        = amt_ff;
      used_in       = used_ff;
      hit_idx_in    = hit_idx_ff;
      hit_valid_in  = hit_valid_ff;
      rd_ptr_in     = rd_ptr_ff;
      chk_idx_in    = chk_idx_ff;
      chk_valid_in  = chk_valid_ff;
      res_status_in = res_status_ff;
      res_off_in    = res_off_ff;
      res_free_in   = res_free_ff;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_free_in   = rsp_free_ff;
      // drop the result once taken
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      wr_en         = 1'b0;
      wr_idx        = '0;
      wr_entry      = '0;
      rd_en         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mode_in      = req_ch.mode;
               off_in       = req_ch.region_offset;
               amt_in       = req_ch.amount;
               rd_ptr_in    = '0;
               chk_valid_in = 1'b0;
               if ((req_ch.mode == MODE_RECORD) || (req_ch.mode == MODE_SEARCH)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end

         ST_SCAN: begin
            rd_en = rd_more;
            if (chk_valid_ff && cmp_hit) begin
               // first match: stop the walk
               if (mode_ff == MODE_RECORD) begin
                  wr_en          = 1'b1;
                  wr_idx         = chk_idx_ff;
                  wr_entry       = '{offset: off_ff, free: amt_ff};
                  res_status_in  = STATUS_OK;
                  res_off_in     = '0;
                  res_free_in    = '0;
               end else begin
                  hit_idx_in     = chk_idx_ff;
                  hit_valid_in   = 1'b1;
                  res_status_in  = STATUS_OK;
                  res_off_in     = rd_entry.offset;
                  res_free_in    = rd_entry.free;
               end
               state_in = ST_DONE;
            end else if (!chk_valid_ff && !rd_more) begin
               // walked every filled entry without a match
               res_off_in  = '0;
               res_free_in = '0;
               if (mode_ff == MODE_RECORD) begin
                  if (used_ff == CNT_W'(ENTRIES)) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     wr_en         = 1'b1;
                     wr_idx        = used_ff[IDX_W-1:0];
                     wr_entry      = '{offset: off_ff, free: amt_ff};
                     used_in       = used_ff + CNT_W'(1);
                     res_status_in = STATUS_APPENDED;
                  end
               end else begin
                  hit_valid_in  = 1'b0;
                  res_status_in = STATUS_NO_FIT;
               end
               state_in = ST_DONE;
            end else begin
               // advance: issue the next read, check the returning one
               if (rd_more) begin
                  rd_ptr_in = rd_ptr_ff + CNT_W'(1);
               end
               chk_valid_in = rd_more;
               chk_idx_in   = rd_ptr_ff[IDX_W-1:0];
            end
         end

         ST_EXEC: begin
            res_off_in    = '0;
            res_free_in   = '0;
            res_status_in = STATUS_OK;
            if (mode_ff == MODE_UPDATE) begin
               if (!hit_valid_ff) begin
                  res_status_in = STATUS_NO_HIT;
               end else begin
                  wr_en    = 1'b1;
                  wr_idx   = hit_idx_ff;
                  wr_entry = '{offset: (amt_ff != '0) ? off_ff : '0, free: amt_ff};
               end
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_off_in    = res_off_ff;
               rsp_free_in   = res_free_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         hit_idx_ff   <= '0;
         hit_valid_ff <= 1'b0;
         rd_ptr_ff    <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         hit_idx_ff   <= hit_idx_in;
         hit_valid_ff <= hit_valid_in;
         rd_ptr_ff    <= rd_ptr_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      off_ff        <= off_in;
      amt_ff        <= amt_in;
      chk_idx_ff    <= chk_idx_in;
      res_status_ff <= res_status_in;
      res_off_ff    <= res_off_in;
      res_free_ff   <= res_free_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.found_offset = rsp_off_ff;
   assign rsp_ch.found_free   = rsp_free_ff;

endmodule : first_fit_free_space_table

`default_nettype wire

### hdl/ffst_table.sv
`default_nettype none

module ffst_table
   import ffst_pkg::*;
#(
   parameter int unsigned ENTRIES = 64,
   parameter int unsigned IDX_W   = 6
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_idx,
   input  wire entry_type        wr_entry,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_idx,
   output      entry_type        rd_entry
);

   entry_type mem [ENTRIES];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= mem[rd_idx];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule : ffst_table

`default_nettype wire
